@@ src/obs_pkg.sv @@
// ----------------------------------------------------------------------------
// obs_pkg
// Shared types and constants for the overlap box suppression block.
// ----------------------------------------------------------------------------
package obs_pkg;

    localparam int COORD_W       = 16;
    localparam int AREA_W        = 32;
    localparam int POS_W         = 15;
    localparam int THR_W         = 16;
    localparam int MAX_KEPT_DEF  = 64;
    localparam int MAX_BOXES_DEF = 32768;

    localparam logic [THR_W-1:0] THR_RESET = 16'd26214;

    typedef struct packed {
        logic               frame_end;
        logic [COORD_W-1:0] bottom_edge;
        logic [COORD_W-1:0] right_edge;
        logic [COORD_W-1:0] top_edge;
        logic [COORD_W-1:0] left_edge;
    } box_t;

    typedef struct packed {
        logic             frame_done;
        logic             store_overflow;
        logic [POS_W-1:0] box_position;
        logic             keep_box;
    } result_t;

    typedef struct packed {
        logic capture;
        logic area;
        logic issue;
        logic finish;
    } obs_cmd_t;

    typedef struct packed {
        logic empty;
        logic scan_last;
        logic busy;
    } obs_stat_t;

    function automatic logic [COORD_W-1:0] span(
        input logic [COORD_W-1:0] lo,
        input logic [COORD_W-1:0] hi
    );
        span = (hi > lo) ? (hi - lo) : '0;
    endfunction

endpackage

@@ src/obs_ctrl.sv @@
// ----------------------------------------------------------------------------
// obs_ctrl
// Sequencer: capture a box, compute its area, scan the kept store, drain the
// compare pipeline and hand the result to the output register.
// ----------------------------------------------------------------------------
module obs_ctrl
    import obs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output obs_cmd_t  cmd,
    input  obs_stat_t stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_AREA  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_AREA;
                end
            end
            ST_AREA:
            begin
                cmd.area   = 1'b1;
                state_next = stat.empty ? ST_DRAIN : ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (stat.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!stat.busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/obs_dp.sv @@
// ----------------------------------------------------------------------------
// obs_dp
// Datapath: box and area registers, kept store, IoU compare pipeline,
// counters and the result register.
// ----------------------------------------------------------------------------
module obs_dp
    import obs_pkg::*;
#(
    parameter int MAX_KEPT  = MAX_KEPT_DEF,
    parameter int MAX_BOXES = MAX_BOXES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  box_t             in_item,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_data,
    input  obs_cmd_t         cmd,
    output obs_stat_t        stat,
    output result_t          out_item
);

    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int IDX_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int UNI_W  = AREA_W + 1;
    localparam int PROD_W = THR_W + UNI_W;
    localparam int POS_LIMIT_I = (MAX_BOXES - 1 < (1 << POS_W) - 1) ?
                                 (MAX_BOXES - 1) : ((1 << POS_W) - 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_I);

    typedef struct packed {
        logic [AREA_W-1:0]  area;
        logic [COORD_W-1:0] bottom_edge;
        logic [COORD_W-1:0] right_edge;
        logic [COORD_W-1:0] top_edge;
        logic [COORD_W-1:0] left_edge;
    } kept_t;

    kept_t mem [MAX_KEPT];

    box_t              box_reg;
    logic [AREA_W-1:0] area_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [CNT_W-1:0]  kept_count_reg, kept_count_next;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    result_t           result_reg;
    logic              suppress_reg;

    kept_t              rd_reg;
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [COORD_W-1:0] iw_reg, ih_reg;
    logic [AREA_W-1:0]  ka_reg;
    logic [AREA_W-1:0]  inter_reg, inter3_reg;
    logic [UNI_W-1:0]   sum_reg;
    logic [PROD_W-1:0]  prod_reg;

    logic [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
    logic [UNI_W-1:0]   uni;
    logic               full;
    logic               keep;

    assign full = (kept_count_reg == CNT_W'(MAX_KEPT));
    assign keep = !suppress_reg;

    assign stat.empty     = (kept_count_reg == '0);
    assign stat.scan_last = (scan_idx_reg == kept_count_reg - CNT_W'(1));
    assign stat.busy      = v1_reg || v2_reg || v3_reg || v4_reg;

    assign out_item = result_reg;

    assign x_lo = (box_reg.left_edge > rd_reg.left_edge) ? box_reg.left_edge
                                                        : rd_reg.left_edge;
    assign x_hi = (box_reg.right_edge < rd_reg.right_edge) ? box_reg.right_edge
                                                          : rd_reg.right_edge;
    assign y_lo = (box_reg.top_edge > rd_reg.top_edge) ? box_reg.top_edge
                                                      : rd_reg.top_edge;
    assign y_hi = (box_reg.bottom_edge < rd_reg.bottom_edge) ? box_reg.bottom_edge
                                                            : rd_reg.bottom_edge;
    assign uni  = sum_reg - {1'b0, inter_reg};

    always_comb
    begin
        kept_count_next = kept_count_reg;
        if (keep && !full)
            kept_count_next = kept_count_reg + CNT_W'(1);
        if (box_reg.frame_end)
            kept_count_next = '0;
    end

    always_comb
    begin
        pos_next = (pos_reg < POS_LIMIT) ? (pos_reg + POS_W'(1)) : POS_LIMIT;
        if (box_reg.frame_end)
            pos_next = '0;
    end

    // store and read the kept boxes
    always_ff @(posedge clk)
    begin
        if (cmd.finish && keep && !full)
            mem[kept_count_reg[IDX_W-1:0]] <= '{area:        area_reg,
                                               bottom_edge: box_reg.bottom_edge,
                                               right_edge:  box_reg.right_edge,
                                               top_edge:    box_reg.top_edge,
                                               left_edge:   box_reg.left_edge};
        if (cmd.issue)
            rd_reg <= mem[scan_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            box_reg <= in_item;
        if (cmd.area)
            area_reg <= AREA_W'(span(box_reg.left_edge, box_reg.right_edge)) *
                        AREA_W'(span(box_reg.top_edge, box_reg.bottom_edge));
        iw_reg     <= span(x_lo, x_hi);
        ih_reg     <= span(y_lo, y_hi);
        ka_reg     <= rd_reg.area;
        inter_reg  <= AREA_W'(iw_reg) * AREA_W'(ih_reg);
        sum_reg    <= {1'b0, area_reg} + {1'b0, ka_reg};
        inter3_reg <= inter_reg;
        prod_reg   <= {{UNI_W{1'b0}}, thr_reg} * {{THR_W{1'b0}}, uni};
        if (cmd.finish)
        begin
            result_reg.keep_box       <= keep;
            result_reg.box_position   <= pos_reg;
            result_reg.store_overflow <= keep && full;
            result_reg.frame_done     <= box_reg.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THR_RESET;
            kept_count_reg <= '0;
            scan_idx_reg   <= '0;
            pos_reg        <= '0;
            suppress_reg   <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_data;
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.capture)
            begin
                scan_idx_reg <= '0;
                suppress_reg <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                // drop the box on any overlap above threshold
                if (v4_reg && ({1'b0, inter3_reg, {THR_W{1'b0}}} > prod_reg))
                    suppress_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                kept_count_reg <= kept_count_next;
                pos_reg        <= pos_next;
            end
        end
    end

endmodule

@@ src/overlap_box_suppression.sv @@
// ----------------------------------------------------------------------------
// overlap_box_suppression
// Greedy IoU non-maximum suppression over score-sorted boxes, one per
// transaction, with a kept store cleared at the end of every frame.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_item  (box_t)
//  out      output     out_valid/out_stall  out_item (result_t)
//  cfg      input      cfg_valid/cfg_ready  cfg_data (overlap threshold)
//
//  After a box is taken its area is computed, then the N boxes kept so far in
//  the frame (at most MAX_KEPT) are scanned, unless the store is empty:
//  one store read per cycle feeds a four-stage compare pipe.
//  The pipe drains and the result is registered before another box is taken.
//  The next box is taken while the previous result waits at the output.
//  A stalled output holds the finished box until the result register frees.
//  Reset clears counters and sets the threshold to 26214; no clearing pass.
// ----------------------------------------------------------------------------
module overlap_box_suppression
    import obs_pkg::*;
#(
    parameter int MAX_KEPT  = MAX_KEPT_DEF,
    parameter int MAX_BOXES = MAX_BOXES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  box_t             in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output result_t          out_item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data
);

    obs_cmd_t  cmd;
    obs_stat_t stat;

    assign cfg_ready = 1'b1;

    obs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    obs_dp #(
        .MAX_KEPT  (MAX_KEPT),
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (out_item)
    );

endmodule

@@ src/obs_checker.sv @@
// ----------------------------------------------------------------------------
// obs_checker
// Port-level checks on the overlap box suppression block.
// ----------------------------------------------------------------------------
module obs_checker
    import obs_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_stall,
    input logic    out_valid,
    input logic    out_stall,
    input result_t out_item
);

    logic after_frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            after_frame_reg <= 1'b1;
        else if (out_valid && !out_stall)
            after_frame_reg <= out_item.frame_done;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_item))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second box taken during a scan");

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && after_frame_reg |-> out_item.box_position == '0)
        else $error("first box of a frame not at position zero");

endmodule

bind overlap_box_suppression obs_checker u_obs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

@@ sim/suppression_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suppression_checker
// Watches the box, result and threshold channels of overlap_box_suppression.
// It keeps its own kept-box store, decides keep, position and overflow for
// every accepted box, and compares each accepted result with the oldest
// decision still waiting.
// ----------------------------------------------------------------------------
module suppression_checker
    import obs_pkg::*;
#(
    parameter int MAX_KEPT  = MAX_KEPT_DEF,
    parameter int MAX_BOXES = MAX_BOXES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  box_t             in_item,
    input  logic             out_valid,
    input  logic             out_stall,
    input  result_t          out_item,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    localparam int POS_CAP = (MAX_BOXES - 1 < 32767) ? MAX_BOXES - 1 : 32767;

    logic [THR_W-1:0]  threshold;
    box_t              kept_box  [MAX_KEPT];
    logic [AREA_W-1:0] kept_area [MAX_KEPT];
    int                kept_total;
    int                next_pos;
    result_t           decisions [$];

    function automatic logic [AREA_W-1:0] extent(
        input logic [COORD_W-1:0] lo,
        input logic [COORD_W-1:0] hi
    );
        return (hi > lo) ? AREA_W'(hi - lo) : '0;
    endfunction

    function automatic logic [COORD_W-1:0] higher(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    function automatic logic [COORD_W-1:0] lower(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic judge_box(input box_t b);
        logic [AREA_W-1:0] area;
        logic [AREA_W-1:0] wide;
        logic [AREA_W-1:0] tall;
        logic [63:0]       common;
        logic [63:0]       joint;
        result_t           r;
        area = extent(b.left_edge, b.right_edge) * extent(b.top_edge, b.bottom_edge);
        r = '0;
        r.keep_box = 1'b1;
        for (int i = 0; i < kept_total; i++)
        begin
            wide = extent(higher(b.left_edge, kept_box[i].left_edge),
                          lower(b.right_edge, kept_box[i].right_edge));
            tall = extent(higher(b.top_edge, kept_box[i].top_edge),
                          lower(b.bottom_edge, kept_box[i].bottom_edge));
            common = 64'(wide) * 64'(tall);
            joint = 64'(area) + 64'(kept_area[i]) - common;
            if ((common << 16) > 64'(threshold) * joint)
                r.keep_box = 1'b0;
        end
        if (r.keep_box)
        begin
            if (kept_total < MAX_KEPT)
            begin
                kept_box[kept_total] = b;
                kept_area[kept_total] = area;
                kept_total++;
            end
            else
                r.store_overflow = 1'b1;
        end
        r.box_position = POS_W'(next_pos);
        r.frame_done = b.frame_end;
        if (next_pos < POS_CAP)
            next_pos++;
        if (b.frame_end)
        begin
            kept_total = 0;
            next_pos = 0;
        end
        decisions.insert(decisions.size(), r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            threshold = THR_RESET;
            kept_total = 0;
            next_pos = 0;
            fail_count = 0;
            decisions.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (decisions.size() == 0)
                    report("unexpected result, position", out_item.box_position, -1);
                else
                begin
                    want = decisions.pop_front();
                    if (out_item.keep_box !== want.keep_box)
                        report("keep_box", out_item.keep_box, want.keep_box);
                    if (out_item.box_position !== want.box_position)
                        report("box_position", out_item.box_position, want.box_position);
                    if (out_item.store_overflow !== want.store_overflow)
                        report("store_overflow", out_item.store_overflow,
                               want.store_overflow);
                    if (out_item.frame_done !== want.frame_done)
                        report("frame_done", out_item.frame_done, want.frame_done);
                end
            end
            if (cfg_valid && cfg_ready)
                threshold = cfg_data;
            if (in_valid && !in_stall)
                judge_box(in_item);
        end
        pending = decisions.size();
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives overlap_box_suppression with directed corner boxes, clustered and
// fully random frames and store-filling frames, under several IoU
// thresholds, random output stalls and random gaps on the input.
// The checker alongside the block predicts and compares every transaction.
// ----------------------------------------------------------------------------
module testbench;
    import obs_pkg::*;

    localparam int CYCLE_LIMIT    = 3000000;
    localparam int RANDOM_ITEMS   = 650;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    box_t             in_item   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    result_t          out_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int cycles     = 0;
    int items_sent = 0;
    int stall_left = 0;
    int calm_left  = 0;
    bit quiet      = 1'b0;
    bit steady     = 1'b0;

    overlap_box_suppression u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    suppression_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("testbench failed");
        $finish;
    end

    // output stall: short bursts, with calm stretches in between
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (calm_left > 0)
            calm_left--;
        else if (!quiet)
        begin
            case ($urandom_range(0, 15))
                0:       calm_left = $urandom_range(30, 300);
                1, 2, 3: stall_left = $urandom_range(1, 3);
                default: ;
            endcase
        end
        out_stall <= (stall_left > 0);
    end

    function automatic logic [COORD_W-1:0] clamp_coord(input int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return COORD_W'(v);
    endfunction

    function automatic int wobble(input int j);
        return int'($urandom_range(0, 2 * j)) - j;
    endfunction

    function automatic box_t make_box(
        input int   l,
        input int   t,
        input int   r,
        input int   b,
        input logic last
    );
        box_t bx;
        bx.left_edge = clamp_coord(l);
        bx.top_edge = clamp_coord(t);
        bx.right_edge = clamp_coord(r);
        bx.bottom_edge = clamp_coord(b);
        bx.frame_end = last;
        return bx;
    endfunction

    function automatic box_t any_box(input logic last);
        box_t bx;
        bx.left_edge = COORD_W'($urandom);
        bx.top_edge = COORD_W'($urandom);
        bx.right_edge = COORD_W'($urandom);
        bx.bottom_edge = COORD_W'($urandom);
        bx.frame_end = last;
        return bx;
    endfunction

    function automatic box_t cluster_box(
        input int   cx,
        input int   cy,
        input int   reach,
        input logic last
    );
        int   hw;
        int   hh;
        int   j;
        box_t bx;
        hw = $urandom_range(1, reach);
        hh = $urandom_range(1, reach);
        j = reach / 4;
        bx = make_box(cx - hw + wobble(j), cy - hh + wobble(j),
                      cx + hw + wobble(j), cy + hh + wobble(j), last);
        case ($urandom_range(0, 11))
            0:       {bx.left_edge, bx.right_edge} = {bx.right_edge, bx.left_edge};
            1:       {bx.top_edge, bx.bottom_edge} = {bx.bottom_edge, bx.top_edge};
            default: ;
        endcase
        return bx;
    endfunction

    // disjoint cells of a 9 x 9 grid
    function automatic box_t grid_box(input int slot, input logic last);
        box_t bx;
        bx.left_edge = COORD_W'((slot % 9) * 7200 + $urandom_range(0, 100));
        bx.top_edge = COORD_W'((slot / 9 % 9) * 7200 + $urandom_range(0, 100));
        bx.right_edge = bx.left_edge + COORD_W'($urandom_range(1, 7000));
        bx.bottom_edge = bx.top_edge + COORD_W'($urandom_range(1, 7000));
        bx.frame_end = last;
        return bx;
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return THR_W'($urandom);
            3:       return 16'd32768;
            4:       return THR_RESET;
            default: return THR_W'($urandom_range(1, 2000));
        endcase
    endfunction

    task automatic send_box(input box_t b);
        int gap;
        gap = (!quiet && !steady && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold the sender until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        drain();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic cluster_frame(input int length);
        int cx;
        int cy;
        int reach;
        cx = $urandom_range(0, 65535);
        cy = $urandom_range(0, 65535);
        reach = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 40) : $urandom_range(40, 6000);
        for (int k = 0; k < length; k++)
        begin
            if ($urandom_range(0, 14) == 0)
                send_box(any_box(k == length - 1));
            else
                send_box(cluster_box(cx, cy, reach, k == length - 1));
        end
        items_sent += length;
    endtask

    task automatic any_frame(input int length);
        for (int k = 0; k < length; k++)
            send_box(any_box(k == length - 1));
        items_sent += length;
    endtask

    // fill the store with disjoint boxes, then push past it
    task automatic fill_frame(input int length);
        for (int k = 0; k < length; k++)
            send_box(grid_box((k < 64) ? k : $urandom_range(0, 80), k == length - 1));
        items_sent += length;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_box(make_box(0, 0, 0, 0, 1'b0));
        send_box(make_box(0, 0, 0, 0, 1'b0));
        send_box(make_box(0, 0, 65535, 65535, 1'b0));
        send_box(make_box(0, 0, 65535, 65535, 1'b0));
        send_box(make_box(65535, 65535, 0, 0, 1'b0));
        send_box(make_box(200, 100, 100, 300, 1'b0));
        send_box(make_box(65535, 65535, 65535, 65535, 1'b0));
        send_box(make_box(0, 0, 32768, 65535, 1'b0));
        send_box(make_box(16384, 0, 65535, 65535, 1'b0));
        send_box(make_box(43690, 21845, 65535, 65535, 1'b0));
        send_box(make_box(21845, 43690, 43690, 65535, 1'b1));
        send_box(make_box(1, 2, 3, 4, 1'b1));
        send_box(make_box(100, 100, 200, 200, 1'b0));
        send_box(make_box(100, 100, 200, 200, 1'b0));
        send_box(make_box(150, 100, 250, 200, 1'b0));
        send_box(make_box(200, 200, 300, 300, 1'b1));

        set_threshold('0);
        send_box(make_box(100, 100, 200, 200, 1'b0));
        send_box(make_box(199, 199, 300, 300, 1'b0));
        send_box(make_box(200, 200, 300, 300, 1'b1));
        set_threshold('1);
        send_box(make_box(100, 100, 200, 200, 1'b0));
        send_box(make_box(100, 100, 200, 200, 1'b0));
        send_box(make_box(100, 100, 200, 201, 1'b1));

        fill_frame(70);
        set_threshold('0);
        cluster_frame(20);
        set_threshold(16'd32768);
        fill_frame(68);

        while (items_sent < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:       fill_frame($urandom_range(65, 72));
                1:       any_frame($urandom_range(1, 6));
                2:       set_threshold(pick_threshold());
                3:       drain();
                default: cluster_frame($urandom_range(1, 30));
            endcase
        end

        quiet = 1'b1;
        steady = 1'b0;
        set_threshold(THR_RESET);
        cluster_frame(20);

        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
